FILE: design/pwlr_pkg.sv
// Package with the shared field types and fixed sizes of the ramp generator.
package pwlr_pkg;

  localparam int TIME_W    = 32;
  localparam int WEIGHT_W  = 32;
  localparam int INDEX_W   = 32;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef logic [TIME_W-1:0]          pwlr_time_t;
  typedef logic signed [WEIGHT_W-1:0] pwlr_weight_t;
  typedef logic [INDEX_W-1:0]         pwlr_index_t;

endpackage

FILE: design/pwlr_if.sv
// Stream interfaces for breakpoint input and sample output of the ramp generator.
interface pwlr_point_if;
  logic                   valid;
  logic                   ready;
  pwlr_pkg::pwlr_time_t   point_time;
  pwlr_pkg::pwlr_weight_t point_weight;
  logic                   starts_interval;

  modport source(output valid, output point_time, output point_weight,
                 output starts_interval, input ready);
  modport sink(input valid, input point_time, input point_weight,
               input starts_interval, output ready);
endinterface

interface pwlr_sample_if;
  logic                   valid;
  logic                   ready;
  pwlr_pkg::pwlr_time_t   sample_time;
  pwlr_pkg::pwlr_weight_t sample_weight;
  pwlr_pkg::pwlr_index_t  store_index;
  logic                   bad_point;
  logic                   last_of_run;

  modport source(output valid, output sample_time, output sample_weight,
                 output store_index, output bad_point, output last_of_run,
                 input ready);
  modport sink(input valid, input sample_time, input sample_weight,
               input store_index, input bad_point, input last_of_run,
               output ready);
endinterface

FILE: design/piecewise_linear_ramp_generator.sv
// Piecewise linear ramp generator: interpolates one weight per time step between breakpoints.
// An interval start or a rejected point goes through S_SINGLE to the output register.
// A ramp point runs the restoring divider for its 32 quotient bits, then emits one sample
// per cycle while the sink accepts samples. A new point is taken only once the previous
// one is done.
// Reset (rst_n low, synchronous) clears the held point, the store index and output valid.
module piecewise_linear_ramp_generator #(
  parameter int MAX_SPAN = 64
) (
  input logic            clk,
  input logic            rst_n,
  pwlr_point_if.sink     in_point,
  pwlr_sample_if.source  out_sample
);

  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int TW     = pwlr_pkg::TIME_W;
  localparam int WW     = pwlr_pkg::WEIGHT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SINGLE,
    S_DIV,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  logic                           have_prev_r, have_prev_nxt;
  pwlr_pkg::pwlr_time_t           prev_time_r, prev_time_nxt;
  pwlr_pkg::pwlr_weight_t         prev_weight_r, prev_weight_nxt;
  pwlr_pkg::pwlr_index_t          idx_r, idx_nxt;

  pwlr_pkg::pwlr_time_t           t_r, t_nxt;
  pwlr_pkg::pwlr_weight_t         w_acc_r, w_acc_nxt;
  logic                           bad_r, bad_nxt;
  logic                           neg_r, neg_nxt;
  logic [SPAN_W-1:0]              span_r, span_nxt;
  logic [SPAN_W-1:0]              k_r, k_nxt;
  logic [SPAN_W-1:0]              rem_r, rem_nxt;
  logic [SPAN_W-1:0]              acc_r, acc_nxt;
  logic [WW-1:0]                  quo_r, quo_nxt;
  logic [pwlr_pkg::DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  logic                           out_valid_r, out_valid_nxt;
  pwlr_pkg::pwlr_time_t           out_time_r, out_time_nxt;
  pwlr_pkg::pwlr_weight_t         out_weight_r, out_weight_nxt;
  pwlr_pkg::pwlr_index_t          out_index_r, out_index_nxt;
  logic                           out_bad_r, out_bad_nxt;
  logic                           out_last_r, out_last_nxt;

  logic                           in_xfer;
  logic                           slot_free;
  logic [TW-1:0]                  diff;
  logic                           reject;
  logic signed [WW:0]             dw;
  logic [WW:0]                    dw_mag;
  logic [SPAN_W:0]                trial;
  logic                           trial_ge;
  logic [SPAN_W:0]                frac_sum;
  logic                           carry;
  pwlr_pkg::pwlr_weight_t         w_step;

  assign in_point.ready = (state_r == S_IDLE);
  assign in_xfer        = in_point.valid && in_point.ready;
  assign slot_free      = !out_valid_r || out_sample.ready;

  assign out_sample.valid         = out_valid_r;
  assign out_sample.sample_time   = out_time_r;
  assign out_sample.sample_weight = out_weight_r;
  assign out_sample.store_index   = out_index_r;
  assign out_sample.bad_point     = out_bad_r;
  assign out_sample.last_of_run   = out_last_r;

  // Point screening and slope magnitude, used at the input transfer.
  assign diff   = in_point.point_time - prev_time_r;
  assign reject = (in_point.point_time <= prev_time_r) || (diff > TW'(MAX_SPAN));
  assign dw     = $signed({in_point.point_weight[WW-1], in_point.point_weight})
                - $signed({prev_weight_r[WW-1], prev_weight_r});
  assign dw_mag = dw[WW] ? (WW+1)'(-dw) : dw;

  // Restoring divider step: |dw| / span, one quotient bit per cycle.
  assign trial    = {rem_r, quo_r[WW-1]};
  assign trial_ge = trial >= {1'b0, span_r};

  // Per-sample step: the fraction k*R/span advances by R and carries at most once.
  assign frac_sum = {1'b0, acc_r} + {1'b0, rem_r};
  assign carry    = frac_sum >= {1'b0, span_r};
  // Truncation toward zero: add Q+carry for rising ramps, subtract it for falling ones.
  assign w_step   = w_acc_r + (neg_r ? ~quo_r : quo_r) + WW'(neg_r ^ carry);

  always_comb begin
    state_nxt       = state_r;
    have_prev_nxt   = have_prev_r;
    prev_time_nxt   = prev_time_r;
    prev_weight_nxt = prev_weight_r;
    idx_nxt         = idx_r;
    t_nxt           = t_r;
    w_acc_nxt       = w_acc_r;
    bad_nxt         = bad_r;
    neg_nxt         = neg_r;
    span_nxt        = span_r;
    k_nxt           = k_r;
    rem_nxt         = rem_r;
    acc_nxt         = acc_r;
    quo_nxt         = quo_r;
    div_cnt_nxt     = div_cnt_r;
    out_valid_nxt   = out_valid_r && !out_sample.ready;
    out_time_nxt    = out_time_r;
    out_weight_nxt  = out_weight_r;
    out_index_nxt   = out_index_r;
    out_bad_nxt     = out_bad_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_point.starts_interval || !have_prev_r) begin
            t_nxt           = in_point.point_time;
            w_acc_nxt       = in_point.point_weight;
            bad_nxt         = 1'b0;
            have_prev_nxt   = 1'b1;
            prev_time_nxt   = in_point.point_time;
            prev_weight_nxt = in_point.point_weight;
            state_nxt       = S_SINGLE;
          end else if (reject) begin
            t_nxt     = in_point.point_time;
            w_acc_nxt = '0;
            bad_nxt   = 1'b1;
            state_nxt = S_SINGLE;
          end else begin
            // The held point can move on now; the ramp starts from the old one.
            t_nxt           = prev_time_r;
            w_acc_nxt       = prev_weight_r;
            neg_nxt         = dw[WW];
            span_nxt        = diff[SPAN_W-1:0];
            quo_nxt         = dw_mag[WW-1:0];
            rem_nxt         = '0;
            acc_nxt         = '0;
            k_nxt           = SPAN_W'(1);
            div_cnt_nxt     = '0;
            prev_time_nxt   = in_point.point_time;
            prev_weight_nxt = in_point.point_weight;
            state_nxt       = S_DIV;
          end
        end
      end
      S_SINGLE: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_time_nxt   = t_r;
          out_weight_nxt = w_acc_r;
          out_index_nxt  = idx_r;
          out_bad_nxt    = bad_r;
          out_last_nxt   = 1'b1;
          if (!bad_r) begin
            idx_nxt = idx_r + 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        rem_nxt     = trial_ge ? SPAN_W'(trial - {1'b0, span_r}) : trial[SPAN_W-1:0];
        quo_nxt     = {quo_r[WW-2:0], trial_ge};
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == pwlr_pkg::DIV_CNT_W'(pwlr_pkg::DIV_STEPS - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_time_nxt   = t_r + 1'b1;
          out_weight_nxt = w_step;
          out_index_nxt  = idx_r;
          out_bad_nxt    = 1'b0;
          out_last_nxt   = (k_r == span_r);
          t_nxt          = t_r + 1'b1;
          w_acc_nxt      = w_step;
          acc_nxt        = carry ? SPAN_W'(frac_sum - {1'b0, span_r})
                                 : frac_sum[SPAN_W-1:0];
          idx_nxt        = idx_r + 1'b1;
          k_nxt          = k_r + 1'b1;
          if (k_r == span_r) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      have_prev_r   <= 1'b0;
      prev_time_r   <= '0;
      prev_weight_r <= '0;
      idx_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      have_prev_r   <= have_prev_nxt;
      prev_time_r   <= prev_time_nxt;
      prev_weight_r <= prev_weight_nxt;
      idx_r         <= idx_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    t_r          <= t_nxt;
    w_acc_r      <= w_acc_nxt;
    bad_r        <= bad_nxt;
    neg_r        <= neg_nxt;
    span_r       <= span_nxt;
    k_r          <= k_nxt;
    rem_r        <= rem_nxt;
    acc_r        <= acc_nxt;
    quo_r        <= quo_nxt;
    div_cnt_r    <= div_cnt_nxt;
    out_time_r   <= out_time_nxt;
    out_weight_r <= out_weight_nxt;
    out_index_r  <= out_index_nxt;
    out_bad_r    <= out_bad_nxt;
    out_last_r   <= out_last_nxt;
  end

  a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_EMIT) |-> (span_r != '0 && span_r <= SPAN_W'(MAX_SPAN)))
    else $error("ramp span out of range");

  a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_EMIT) |-> (rem_r < span_r))
    else $error("divider remainder not below span");

  a_frac_below_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> (acc_r < span_r && k_r != '0 && k_r <= span_r))
    else $error("ramp fraction or step counter out of range");

  a_bad_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |-> (out_weight_r == '0 && out_last_r))
    else $error("error result with nonzero weight or not last");

  a_ramp_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && slot_free && k_r == span_r) |=>
      (state_r == S_IDLE && out_valid_r && out_last_r && out_weight_r == prev_weight_r))
    else $error("ramp did not end on the breakpoint weight");

endmodule

FILE: bench/pwlr_ramp_checker.sv
// Checker that predicts the ramp generator's samples and compares them with its output.
module pwlr_ramp_checker #(
  parameter int MAX_SPAN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  pwlr_point_if       point,
  pwlr_sample_if      sample,
  output int unsigned fail_total,
  output int unsigned samples_pending,
  output int unsigned samples_checked,
  output int unsigned rejects_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REPORT_LIMIT = 10;

  typedef struct {
    pwlr_pkg::pwlr_time_t   sample_time;
    pwlr_pkg::pwlr_weight_t sample_weight;
    pwlr_pkg::pwlr_index_t  store_index;
    logic                   bad_point;
    logic                   last_of_run;
  } ramp_sample_t;

  ramp_sample_t           ramp_samples_due[$];
  logic                   holding = 1'b0;
  pwlr_pkg::pwlr_time_t   anchor_time = '0;
  pwlr_pkg::pwlr_weight_t anchor_weight = '0;
  pwlr_pkg::pwlr_index_t  index_next = '0;
  int unsigned            fail_count = 0;
  int unsigned            sample_count = 0;
  int unsigned            reject_count = 0;

  function automatic ramp_sample_t make_sample(input pwlr_pkg::pwlr_time_t t,
                                               input pwlr_pkg::pwlr_weight_t w,
                                               input pwlr_pkg::pwlr_index_t idx,
                                               input logic bad,
                                               input logic last);
    ramp_sample_t s;
    s.sample_time   = t;
    s.sample_weight = w;
    s.store_index   = idx;
    s.bad_point     = bad;
    s.last_of_run   = last;
    return s;
  endfunction

  // Works out every sample one breakpoint causes and queues them in order.
  function automatic void predict_ramp(input pwlr_pkg::pwlr_time_t t,
                                       input pwlr_pkg::pwlr_weight_t w,
                                       input logic opens);
    pwlr_pkg::pwlr_time_t span;
    longint               base;
    longint               delta;
    longint               value;
    span = t - anchor_time;
    if (opens || !holding) begin
      ramp_samples_due.push_back(make_sample(t, w, index_next, 1'b0, 1'b1));
      index_next++;
      holding       = 1'b1;
      anchor_time   = t;
      anchor_weight = w;
    end else if (t <= anchor_time || span > pwlr_pkg::pwlr_time_t'(MAX_SPAN)) begin
      // A rejected point leaves the held point and the store index alone.
      ramp_samples_due.push_back(make_sample(t, '0, index_next, 1'b1, 1'b1));
    end else begin
      base  = longint'(anchor_weight);
      delta = longint'(w) - base;
      for (int unsigned k = 1; k <= span; k++) begin
        // SystemVerilog division truncates toward zero, as the ramp requires.
        value = base + (delta * longint'(k)) / longint'(span);
        ramp_samples_due.push_back(make_sample(anchor_time + pwlr_pkg::pwlr_time_t'(k),
                                               pwlr_pkg::pwlr_weight_t'(value), index_next,
                                               1'b0, k == span));
        index_next++;
      end
      anchor_time   = t;
      anchor_weight = w;
    end
  endfunction

  always @(posedge clk) begin
    ramp_sample_t want;
    if (!rst_n) begin
      ramp_samples_due.delete();
      holding       = 1'b0;
      anchor_time   = '0;
      anchor_weight = '0;
      index_next    = '0;
    end else begin
      if (point.valid && point.ready) begin
        predict_ramp(point.point_time, point.point_weight, point.starts_interval);
      end
      if (sample.valid && sample.ready) begin
        if (ramp_samples_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("unexpected sample: t=%h w=%h idx=%0d bad=%b last=%b",
                     sample.sample_time, sample.sample_weight, sample.store_index,
                     sample.bad_point, sample.last_of_run);
          end
        end else begin
          want = ramp_samples_due.pop_front();
          if (sample.sample_time !== want.sample_time ||
              sample.sample_weight !== want.sample_weight ||
              sample.store_index !== want.store_index ||
              sample.bad_point !== want.bad_point ||
              sample.last_of_run !== want.last_of_run) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("sample %0d expected t=%h w=%h idx=%0d bad=%b last=%b", sample_count,
                       want.sample_time, want.sample_weight, want.store_index,
                       want.bad_point, want.last_of_run);
              $display("sample %0d got      t=%h w=%h idx=%0d bad=%b last=%b", sample_count,
                       sample.sample_time, sample.sample_weight, sample.store_index,
                       sample.bad_point, sample.last_of_run);
            end
          end
          sample_count++;
          if (want.bad_point) begin
            reject_count++;
          end
        end
      end
    end
    fail_total      <= fail_count;
    samples_pending <= ramp_samples_due.size();
    samples_checked <= sample_count;
    rejects_checked <= reject_count;
  end

endmodule

FILE: bench/piecewise_linear_ramp_generator_test.sv
// Top of the ramp generator testbench: clock, reset, breakpoint stimulus and the verdict.
module piecewise_linear_ramp_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RAMP_MAX_SPAN = 64;
  localparam int POINT_COUNT   = 450;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 120;
  localparam int IDLE_PERCENT  = 20;

  localparam pwlr_pkg::pwlr_weight_t WEIGHT_MAX = 32'sh7FFF_FFFF;
  localparam pwlr_pkg::pwlr_weight_t WEIGHT_MIN = 32'sh8000_0000;

  logic                 clk;
  logic                 rst_n;
  logic                 steady_flow = 1'b0;
  logic                 holding = 1'b0;
  pwlr_pkg::pwlr_time_t anchor_time = '0;
  int unsigned          points_sent = 0;
  int unsigned          idle_cycles = 0;
  int unsigned          fail_total;
  int unsigned          samples_pending;
  int unsigned          samples_checked;
  int unsigned          rejects_checked;

  pwlr_point_if  point_ch();
  pwlr_sample_if sample_ch();

  piecewise_linear_ramp_generator #(
    .MAX_SPAN(RAMP_MAX_SPAN)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_point(point_ch),
    .out_sample(sample_ch)
  );

  pwlr_ramp_checker #(
    .MAX_SPAN(RAMP_MAX_SPAN)
  ) ramp_checker (
    .clk(clk),
    .rst_n(rst_n),
    .point(point_ch),
    .sample(sample_ch),
    .fail_total(fail_total),
    .samples_pending(samples_pending),
    .samples_checked(samples_checked),
    .rejects_checked(rejects_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The sample sink stalls at random except during the steady stretch.
  initial begin
    sample_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      sample_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Ends a hung run: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (point_ch.valid && point_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_point(input pwlr_pkg::pwlr_time_t t, input pwlr_pkg::pwlr_weight_t w,
                            input logic opens);
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
      point_ch.valid <= 1'b0;
      @(posedge clk);
    end
    point_ch.valid           <= 1'b1;
    point_ch.point_time      <= t;
    point_ch.point_weight    <= w;
    point_ch.starts_interval <= opens;
    @(posedge clk);
    while (!point_ch.ready) begin
      @(posedge clk);
    end
    points_sent++;
    // Keep track of the held point so that most random points form real ramps.
    if (opens || !holding) begin
      holding     = 1'b1;
      anchor_time = t;
    end else if (t > anchor_time && t - anchor_time <= RAMP_MAX_SPAN) begin
      anchor_time = t;
    end
  endtask

  task automatic wait_for_drain();
    point_ch.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (samples_pending != 0);
  endtask

  function automatic pwlr_pkg::pwlr_weight_t pick_weight();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return WEIGHT_MAX;
    end else if (r == 1) begin
      return WEIGHT_MIN;
    end else if (r < 6) begin
      return pwlr_pkg::pwlr_weight_t'($urandom());
    end
    return pwlr_pkg::pwlr_weight_t'(int'($urandom_range(0, 200000)) - 100000);
  endfunction

  // Mostly short spans, with a few up to the largest allowed.
  function automatic int unsigned pick_span();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 8);
    end else if (r < 90) begin
      return $urandom_range(9, 32);
    end
    return $urandom_range(33, RAMP_MAX_SPAN);
  endfunction

  initial begin
    int unsigned          r;
    pwlr_pkg::pwlr_time_t t;
    logic                 opens;
    rst_n                    <= 1'b0;
    point_ch.valid           <= 1'b0;
    point_ch.point_time      <= '0;
    point_ch.point_weight    <= '0;
    point_ch.starts_interval <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // The first point after reset stands alone even without its start flag.
    send_point(32'd100, WEIGHT_MAX, 1'b0);
    send_point(32'd164, WEIGHT_MIN, 1'b0);
    send_point(32'd164, 32'sd0, 1'b0);
    send_point(32'd0, 32'sd0, 1'b0);
    send_point(32'd229, 32'sd0, 1'b0);
    send_point(32'd165, 32'sd0, 1'b0);
    send_point(32'd172, -32'sd1000, 1'b0);
    send_point(32'd175, 32'sh0001_0000, 1'b0);
    // Interval starts skip the time check, even going backwards or repeating a time.
    send_point(32'd50, 32'sd123, 1'b1);
    send_point(32'd50, -32'sd5, 1'b1);
    send_point(32'd51, 32'sd5, 1'b0);
    send_point(32'hFFFF_FFC0, WEIGHT_MAX, 1'b1);
    send_point(32'hFFFF_FFFF, WEIGHT_MIN, 1'b0);
    send_point(32'h0000_0005, 32'sd0, 1'b0);
    send_point(32'hFFFF_FFFF, 32'sd7, 1'b1);
    send_point(32'd0, 32'sd0, 1'b1);
    send_point(32'd64, WEIGHT_MAX, 1'b0);
    send_point(32'd128, WEIGHT_MAX, 1'b0);
    send_point(32'hAAAA_AAAA, 32'sh5555_5555, 1'b1);
    send_point(32'hAAAA_AAD2, 32'shAAAA_AAAA, 1'b0);
    send_point(32'h5555_5555, -32'sd1, 1'b1);
    send_point(32'h5555_5556, 32'sd1, 1'b0);
    wait_for_drain();

    for (int n = 0; n < POINT_COUNT; n++) begin
      if (n == 200) begin
        wait_for_drain();
      end
      if (n == 260) begin
        steady_flow <= 1'b1;
      end else if (n == 340) begin
        steady_flow <= 1'b0;
      end
      r     = $urandom_range(0, 99);
      opens = 1'b0;
      if (r < 12) begin
        t     = $urandom();
        opens = 1'b1;
      end else if (r < 80) begin
        t = anchor_time + pick_span();
      end else if (r < 88) begin
        t = anchor_time - $urandom_range(0, 100);
      end else if (r < 94) begin
        t = anchor_time + $urandom_range(RAMP_MAX_SPAN + 1, 1000);
      end else begin
        t = $urandom();
      end
      send_point(t, pick_weight(), opens);
    end
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d breakpoints: ramps of every span, interval starts and rejected points,",
             points_sent);
    $display("with a drained pause and a stall-free stretch; %0d samples checked, %0d rejects.",
             samples_checked, rejects_checked);
    if (fail_total == 0 && samples_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
